### hdl/splat_attribute_activation_defines.svh
// assertion macros for the splat attribute activation block
`ifndef SPLAT_ATTRIBUTE_ACTIVATION_DEFINES_SVH
`define SPLAT_ATTRIBUTE_ACTIVATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SAA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("splat attribute activation check failed");
// expression must never be true outside reset
`define SAA_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("splat attribute activation check failed");
`else
`define SAA_ASSERT(lbl, clk, rst_n, prop)
`define SAA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### hdl/saa_pkg.sv
package saa_pkg;

    // default module parameters
    localparam int INDEX_WIDTH = 24;
    localparam int FRAC_BITS   = 16;

    // fixed field widths
    localparam int IN_W       = 24;
    localparam int SCALE_W    = 32;
    localparam int CH_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAXV_W     = 25;
    localparam int STRIDE_W   = 16;
    localparam int MASK_W     = 7;

    // exp table, power of two depth
    localparam int EXP_TABLE_DEPTH = 64;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

    // fixed-point constants
    localparam logic [31:0] C_LOG2E_LO   = 32'd1901360723; // log2(e) in Q32 minus 2^32
    localparam logic [29:0] C_LN2_Q30    = 30'd744261118;
    localparam logic [30:0] C_SH_C0      = 31'd1211587905;
    localparam logic [21:0] C_DIV6_RECIP = 22'd2796203;    // ceil(2^24 / 6)
    localparam logic [31:0] ONE_Q30      = 32'h4000_0000;

    // cycle counts
    localparam int EXP_LAT  = 8;
    localparam int DIV_BITS = 18;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VERTICES = 3'd0,
        CFG_STRIDE_COUNT = 3'd1,
        CFG_MIN_OPACITY  = 3'd2,
        CFG_MAX_SCALE    = 3'd3,
        CFG_PRESENT_MASK = 3'd4
    } t_cfg_reg;

    // merge stage status
    typedef struct packed {
        logic busy;
        logic done;
        logic scale_over;
    } t_mrg_stat;

    typedef logic [EXP_TABLE_DEPTH-1:0][31:0] t_exp_tab;

    // 2^(k/D) in Q30 as a floored Taylor series of exp(k*ln2/D)
    function automatic t_exp_tab build_exp_tab();
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        t_exp_tab    tab;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            z    = (64'(k) * 64'(C_LN2_Q30)) / EXP_TABLE_DEPTH;
            sum  = 64'(ONE_Q30);
            term = 64'(ONE_Q30);
            term = ((term * z) >> 30) / 64'd1;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd2;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd3;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd4;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd5;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd6;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd7;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd8;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd9;  sum = sum + term;
            term = ((term * z) >> 30) / 64'd10; sum = sum + term;
            term = ((term * z) >> 30) / 64'd11; sum = sum + term;
            term = ((term * z) >> 30) / 64'd12; sum = sum + term;
            term = ((term * z) >> 30) / 64'd13; sum = sum + term;
            term = ((term * z) >> 30) / 64'd14; sum = sum + term;
            term = ((term * z) >> 30) / 64'd15; sum = sum + term;
            term = ((term * z) >> 30) / 64'd16; sum = sum + term;
            term = ((term * z) >> 30) / 64'd17; sum = sum + term;
            term = ((term * z) >> 30) / 64'd18; sum = sum + term;
            term = ((term * z) >> 30) / 64'd19; sum = sum + term;
            term = ((term * z) >> 30) / 64'd20; sum = sum + term;
            tab[k] = sum[31:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

### hdl/saa_exp_lane.sv
module saa_exp_lane #(
    parameter int ATT_W     = 24,
    parameter int FRAC_BITS = saa_pkg::FRAC_BITS,
    parameter int N_W       = 10
) (
    input  logic                    i_clk,
    input  logic signed [ATT_W-1:0] i_arg,
    output logic [31:0]             o_mant,
    output logic [N_W-1:0]          o_exp
);

    localparam int LO_W   = ATT_W + 33;
    localparam int FULL_W = ATT_W + 34;
    localparam int FLO_W  = 32 - saa_pkg::EXP_IDX_W;
    localparam logic signed [32:0] C_LO_S = {1'b0, saa_pkg::C_LOG2E_LO};

    logic signed [LO_W-1:0]   r_lo;
    logic signed [FULL_W-1:0] r_full;
    logic [25:0]              r_a;
    logic [51:0]              r_aa;
    logic [47:0]              r_cube;
    logic [20:0]              r_sq;
    logic [15:0]              r_cube6;
    logic [31:0]              r_m;
    logic [31:0]              r_mant;

    logic signed [LO_W-1:0]   n_lo;
    logic signed [FULL_W-1:0] n_full;
    logic [FLO_W-1:0]         w_flo;
    logic [saa_pkg::EXP_IDX_W-1:0] w_k;
    logic [63:0]              w_a_prod;
    logic [41:0]              w_c6_prod;
    logic [63:0]              w_mant_prod;

    // x * log2(e) split as x * 2^32 + x * low part
    always_comb begin
        n_lo   = LO_W'(i_arg) * LO_W'(C_LO_S);
        n_full = (FULL_W'(i_arg) <<< 32) + FULL_W'(r_lo);
    end

    // fraction split into table index and remainder
    assign w_flo       = r_full[FRAC_BITS+FLO_W-1:FRAC_BITS];
    assign w_k         = r_full[FRAC_BITS+31 -: saa_pkg::EXP_IDX_W];
    assign w_a_prod    = 64'(w_flo) * 64'(saa_pkg::C_LN2_Q30);
    assign w_c6_prod   = 42'(r_cube[47:30]) * 42'(saa_pkg::C_DIV6_RECIP);
    assign w_mant_prod = 64'(saa_pkg::EXP_TAB[w_k]) * 64'(r_m);

    // polynomial pipeline, inputs are held stable during the item
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_full  <= n_full;
        r_a     <= w_a_prod[57:32];
        r_aa    <= 52'(r_a) * 52'(r_a);
        r_cube  <= 48'(r_aa[51:30]) * 48'(r_a);
        r_sq    <= r_aa[51:31];
        r_cube6 <= w_c6_prod[39:24];
        r_m     <= saa_pkg::ONE_Q30 + 32'(r_a) + 32'(r_sq) + 32'(r_cube6);
        r_mant  <= w_mant_prod[61:30];
    end

    assign o_mant = r_mant;
    assign o_exp  = r_full[FULL_W-1:32+FRAC_BITS];

endmodule

### hdl/saa_color_lane.sv
module saa_color_lane #(
    parameter int ATT_W     = 24,
    parameter int FRAC_BITS = saa_pkg::FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic signed [ATT_W-1:0] i_term,
    output logic [saa_pkg::CH_W-1:0] o_chan
);

    localparam int PW = ATT_W + 32;
    localparam logic signed [31:0] C_SH_S = {1'b0, saa_pkg::C_SH_C0};

    logic signed [PW-1:0] r_prod;
    logic [saa_pkg::CH_W-1:0] r_chan;
    logic signed [PW-1:0] w_rnd;
    logic signed [PW-1:0] w_q;
    logic signed [PW-1:0] w_c;

    // round half up, offset by one half, clamp to unit range
    always_comb begin
        w_rnd = r_prod + (PW'(1) <<< (FRAC_BITS + 15));
        w_q   = w_rnd >>> (FRAC_BITS + 16);
        w_c   = w_q + PW'(32768);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_term) * PW'(C_SH_S);
        if (w_c < 0) begin
            r_chan <= '0;
        end else if (w_c > PW'(65535)) begin
            r_chan <= '1;
        end else begin
            r_chan <= w_c[saa_pkg::CH_W-1:0];
        end
    end

    assign o_chan = r_chan;

endmodule

### hdl/saa_merge.sv
module saa_merge #(
    parameter int N_W = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_neg,
    input  logic [3:0][31:0]       i_mant,
    input  logic [3:0][N_W-1:0]    i_exp,
    input  logic [saa_pkg::SCALE_W-1:0] i_max_scale,
    output logic [2:0][saa_pkg::SCALE_W-1:0] o_scale,
    output logic [saa_pkg::CH_W-1:0] o_opacity,
    output saa_pkg::t_mrg_stat     o_stat
);

    localparam int CNT_W = $clog2(saa_pkg::DIV_BITS);
    localparam int DB    = saa_pkg::DIV_BITS;

    logic                r_busy;
    logic                r_load;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [2:0][31:0]    r_scale;
    logic [30:0]         r_e;
    logic                r_neg;
    logic [31:0]         r_den;
    logic [31:0]         r_rem;
    logic [DB-1:0]       r_lo;
    logic [DB-1:0]       r_q;

    logic [31:0]         w_den;
    logic [47:0]         w_num;
    logic [32:0]         w_trial;
    logic                w_ge;
    logic [31:0]         w_e_raw;

    // right shift by 1..62 with round half up
    function automatic logic [31:0] rshift_round(input logic [31:0] x, input logic [5:0] sh);
        logic [63:0] t;
        t = (64'(x) + (64'd1 << (sh - 6'd1))) >> sh;
        return t[31:0];
    endfunction

    // mantissa times 2^(n-10) in Q20, saturated
    function automatic logic [31:0] to_q20(input logic [31:0] mant, input logic [N_W-1:0] n);
        logic signed [N_W:0] s;
        logic signed [N_W:0] sh;
        logic [34:0]         w;
        s  = (N_W+1)'($signed(n)) - (N_W+1)'(10);
        sh = -s;
        w  = 35'(mant) << s[1:0];
        if (s >= 3) begin
            return '1;
        end else if (s >= 0) begin
            return (w > 35'h0_FFFF_FFFF) ? '1 : w[31:0];
        end else if (sh > 62) begin
            return '0;
        end else begin
            return rshift_round(mant, sh[5:0]);
        end
    endfunction

    // exp(-|x|) in Q30 from the opacity lane
    always_comb begin
        logic signed [N_W:0] nsh;
        nsh = -((N_W+1)'($signed(i_exp[3])));
        if (nsh <= 0) begin
            w_e_raw = i_mant[3];
        end else if (nsh > 62) begin
            w_e_raw = '0;
        end else begin
            w_e_raw = rshift_round(i_mant[3], nsh[5:0]);
        end
    end

    // rounded dividend and divisor of the sigmoid
    always_comb begin
        w_den   = saa_pkg::ONE_Q30 + 32'(r_e);
        w_num   = (r_neg ? {1'b0, r_e, 16'b0} : (48'd1 << 46)) + 48'(w_den >> 1);
        w_trial = {r_rem, r_lo[DB-1]};
        w_ge    = w_trial >= {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_load <= i_start;
            if (r_load) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DB - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: capture, prepare, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int j = 0; j < 3; j++) begin
                r_scale[j] <= to_q20(i_mant[j], i_exp[j]);
            end
            r_e   <= (w_e_raw > saa_pkg::ONE_Q30) ? 31'(saa_pkg::ONE_Q30) : w_e_raw[30:0];
            r_neg <= i_neg;
        end
        if (r_load) begin
            r_den <= w_den;
            r_rem <= 32'(w_num[47:DB]);
            r_lo  <= w_num[DB-1:0];
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
            r_lo  <= r_lo << 1;
            r_q   <= {r_q[DB-2:0], w_ge};
        end
    end

    assign o_scale   = r_scale;
    assign o_opacity = (r_q > DB'(65535)) ? '1 : r_q[15:0];

    always_comb begin
        o_stat.busy       = r_busy | r_load;
        o_stat.done       = r_done;
        o_stat.scale_over = (r_scale[0] > i_max_scale) | (r_scale[1] > i_max_scale)
                          | (r_scale[2] > i_max_scale);
    end

endmodule

### hdl/splat_attribute_activation.sv
// Splat attribute activation: takes one vertex of raw Q8.16 attributes a beat and
// returns exp of the three log scales (Q12.20, saturated), the three colour channels
// (0.5 + SH C0 * term, clamped, Q0.16) and the sigmoid of the opacity logit, or
// nothing when the vertex is past max_vertices, off the stride, below min_opacity
// or has a scale above max_scale. Absent attributes (present_mask bit clear) take
// their defaults. One vertex is in flight at a time and goes from accept to the next
// accept through the accept cycle, eight stages of the shared-form exp lanes, a
// capture and a load step in the merge stage, the bit-serial sigmoid divider, a step
// to see the divider finish and a step to move the result into the output register.
// A finished result waits there without blocking the next input beat; a second kept
// result holds the block until the first has left. Configuration writes are always
// ready.
`include "splat_attribute_activation_defines.svh"
module splat_attribute_activation #(
    parameter int INDEX_WIDTH = saa_pkg::INDEX_WIDTH,
    parameter int FRAC_BITS   = saa_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input vertex channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_first_vertex,
    input  logic signed [saa_pkg::IN_W-1:0] i_log_scale_a,
    input  logic signed [saa_pkg::IN_W-1:0] i_log_scale_b,
    input  logic signed [saa_pkg::IN_W-1:0] i_log_scale_c,
    input  logic signed [saa_pkg::IN_W-1:0] i_color_term_r,
    input  logic signed [saa_pkg::IN_W-1:0] i_color_term_g,
    input  logic signed [saa_pkg::IN_W-1:0] i_color_term_b,
    input  logic signed [saa_pkg::IN_W-1:0] i_opacity_logit,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [INDEX_WIDTH-1:0]       o_vertex_index,
    output logic [saa_pkg::SCALE_W-1:0]  o_scale_a,
    output logic [saa_pkg::SCALE_W-1:0]  o_scale_b,
    output logic [saa_pkg::SCALE_W-1:0]  o_scale_c,
    output logic [saa_pkg::CH_W-1:0]     o_red,
    output logic [saa_pkg::CH_W-1:0]     o_green,
    output logic [saa_pkg::CH_W-1:0]     o_blue,
    output logic [saa_pkg::CH_W-1:0]     o_opacity,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [saa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [saa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ATT_W  = (FRAC_BITS + 5 > saa_pkg::IN_W) ? FRAC_BITS + 5 : saa_pkg::IN_W;
    localparam int N_W    = ATT_W + 2 - FRAC_BITS;
    localparam int VCNT_W = INDEX_WIDTH + 1;
    localparam int CMP_W  = (VCNT_W > saa_pkg::MAXV_W) ? VCNT_W : saa_pkg::MAXV_W;
    localparam int LCNT_W = $clog2(saa_pkg::EXP_LAT + 1);
    localparam logic signed [ATT_W-1:0] DEF_LOG_SCALE = -ATT_W'(9 << (FRAC_BITS - 1));
    localparam logic signed [ATT_W-1:0] DEF_LOGIT     = ATT_W'(10 << FRAC_BITS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } t_state;

    t_state r_state;
    logic [LCNT_W-1:0] r_cnt;

    // configuration registers
    logic [saa_pkg::MAXV_W-1:0]   r_max_vertices;
    logic [saa_pkg::STRIDE_W-1:0] r_stride_count;
    logic [saa_pkg::CH_W-1:0]     r_min_opacity;
    logic [saa_pkg::SCALE_W-1:0]  r_max_scale;
    logic [saa_pkg::MASK_W-1:0]   r_present_mask;

    // file position
    logic [VCNT_W-1:0]            r_vcount;
    logic [saa_pkg::STRIDE_W-1:0] r_phase;

    // held vertex
    logic signed [ATT_W-1:0] r_exp_arg [4];
    logic signed [ATT_W-1:0] r_col_arg [3];
    logic                    r_neg;
    logic                    r_pre_keep;
    logic [INDEX_WIDTH-1:0]  r_idx;

    // output register
    logic                          r_out_valid;
    logic [INDEX_WIDTH-1:0]        r_out_index;
    logic [2:0][saa_pkg::SCALE_W-1:0] r_out_scale;
    logic [2:0][saa_pkg::CH_W-1:0] r_out_col;
    logic [saa_pkg::CH_W-1:0]      r_out_opacity;

    logic                          w_in_acc;
    logic                          w_start;
    logic                          w_keep;
    logic                          w_out_free;
    logic signed [ATT_W-1:0]       w_att [7];
    logic [VCNT_W-1:0]             w_idx;
    logic [saa_pkg::STRIDE_W-1:0]  w_phase;
    logic [saa_pkg::STRIDE_W-1:0]  w_sc_m1;
    logic [3:0][31:0]              w_mant;
    logic [3:0][N_W-1:0]           w_exp;
    logic [2:0][saa_pkg::CH_W-1:0] w_col;
    logic [2:0][saa_pkg::SCALE_W-1:0] w_scale;
    logic [saa_pkg::CH_W-1:0]      w_opacity;
    saa_pkg::t_mrg_stat            w_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_start     = (r_state == ST_CALC) && (r_cnt == '0);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_keep      = r_pre_keep && (w_opacity >= r_min_opacity) && !w_stat.scale_over;

    // attribute selection with defaults for absent ones
    always_comb begin
        w_att[0] = r_present_mask[0] ? ATT_W'(i_log_scale_a)   : DEF_LOG_SCALE;
        w_att[1] = r_present_mask[1] ? ATT_W'(i_log_scale_b)   : DEF_LOG_SCALE;
        w_att[2] = r_present_mask[2] ? ATT_W'(i_log_scale_c)   : DEF_LOG_SCALE;
        w_att[3] = r_present_mask[3] ? ATT_W'(i_color_term_r)  : '0;
        w_att[4] = r_present_mask[4] ? ATT_W'(i_color_term_g)  : '0;
        w_att[5] = r_present_mask[5] ? ATT_W'(i_color_term_b)  : '0;
        w_att[6] = r_present_mask[6] ? ATT_W'(i_opacity_logit) : DEF_LOGIT;
    end

    // index and stride phase of this vertex
    always_comb begin
        w_idx   = i_first_vertex ? '0 : r_vcount;
        w_phase = i_first_vertex ? '0 : r_phase;
        w_sc_m1 = (r_stride_count == '0) ? '0 : r_stride_count - 1'b1;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vertices <= saa_pkg::MAXV_W'(1 << 24);
            r_stride_count <= saa_pkg::STRIDE_W'(1);
            r_min_opacity  <= '0;
            r_max_scale    <= '1;
            r_present_mask <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                saa_pkg::CFG_MAX_VERTICES: r_max_vertices <= i_cfg_data[saa_pkg::MAXV_W-1:0];
                saa_pkg::CFG_STRIDE_COUNT: r_stride_count <= i_cfg_data[saa_pkg::STRIDE_W-1:0];
                saa_pkg::CFG_MIN_OPACITY:  r_min_opacity  <= i_cfg_data[saa_pkg::CH_W-1:0];
                saa_pkg::CFG_MAX_SCALE:    r_max_scale    <= i_cfg_data;
                saa_pkg::CFG_PRESENT_MASK: r_present_mask <= i_cfg_data[saa_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and file position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_vcount <= '0;
            r_phase  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state  <= ST_CALC;
                        r_cnt    <= LCNT_W'(saa_pkg::EXP_LAT);
                        r_phase  <= (w_phase >= w_sc_m1) ? '0 : w_phase + 1'b1;
                        r_vcount <= (w_idx == '1) ? w_idx : w_idx + 1'b1;
                    end
                end
                ST_CALC: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_stat.done) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!w_keep || w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // capture the vertex
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int j = 0; j < 3; j++) begin
                r_exp_arg[j] <= w_att[j];
                r_col_arg[j] <= w_att[3+j];
            end
            r_exp_arg[3] <= (w_att[6] < 0) ? w_att[6] : -w_att[6];
            r_neg        <= w_att[6] < 0;
            r_idx        <= w_idx[INDEX_WIDTH-1:0];
            r_pre_keep   <= (CMP_W'(w_idx) < CMP_W'(r_max_vertices)) && (w_phase == '0);
        end
    end

    // exp lanes: three scales and the opacity
    for (genvar g = 0; g < 4; g++) begin : g_exp
        saa_exp_lane #(
            .ATT_W     (ATT_W),
            .FRAC_BITS (FRAC_BITS),
            .N_W       (N_W)
        ) u_exp (
            .i_clk  (i_clk),
            .i_arg  (r_exp_arg[g]),
            .o_mant (w_mant[g]),
            .o_exp  (w_exp[g])
        );
    end

    // colour lanes
    for (genvar g = 0; g < 3; g++) begin : g_col
        saa_color_lane #(
            .ATT_W     (ATT_W),
            .FRAC_BITS (FRAC_BITS)
        ) u_col (
            .i_clk  (i_clk),
            .i_term (r_col_arg[g]),
            .o_chan (w_col[g])
        );
    end

    // scale conversion, sigmoid divide and prune checks
    saa_merge #(
        .N_W (N_W)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_neg       (r_neg),
        .i_mant      (w_mant),
        .i_exp       (w_exp),
        .i_max_scale (r_max_scale),
        .o_scale     (w_scale),
        .o_opacity   (w_opacity),
        .o_stat      (w_stat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_HOLD && w_keep && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_HOLD && w_keep && w_out_free) begin
            r_out_index   <= r_idx;
            r_out_scale   <= w_scale;
            r_out_col     <= w_col;
            r_out_opacity <= w_opacity;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = r_out_index;
    assign o_scale_a      = r_out_scale[0];
    assign o_scale_b      = r_out_scale[1];
    assign o_scale_c      = r_out_scale[2];
    assign o_red          = r_out_col[0];
    assign o_green        = r_out_col[1];
    assign o_blue         = r_out_col[2];
    assign o_opacity      = r_out_opacity;

    // checks
    `SAA_ASSERT(a_out_from_hold, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ST_HOLD))
    `SAA_NEVER(a_merge_idle, i_clk, i_rst_n, w_stat.busy && r_state == ST_IDLE)
    `SAA_ASSERT(a_done_in_div, i_clk, i_rst_n, w_stat.done |-> r_state == ST_DIV)

endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SETTLE_CYC   = 40;
    localparam int  TAB_DEPTH    = 64;
    localparam int  INDEX_BITS   = 24;
    localparam int  FRAC_BITS    = saa_pkg::FRAC_BITS;
    localparam logic [saa_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam longint LOG2E_Q32 = 64'sd6196328019;
    localparam longint SH_C0_Q32 = 64'sd1211587905;
    localparam bit [63:0] LN2_Q30 = 64'd744261118;
    localparam bit [63:0] ONE_Q30_64 = 64'd1 << 30;

    // activated vertex as it leaves the block
    typedef struct {
        bit [23:0] index;
        bit [31:0] scale_a;
        bit [31:0] scale_b;
        bit [31:0] scale_c;
        bit [15:0] red;
        bit [15:0] green;
        bit [15:0] blue;
        bit [15:0] opacity;
    } t_splat_rec;

    // one directed vertex
    typedef struct {
        bit         first;
        bit [23:0]  attr [7];
        bit         typed;
        t_splat_rec want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_first_vertex;
    logic signed [saa_pkg::IN_W-1:0] i_log_scale_a, i_log_scale_b, i_log_scale_c;
    logic signed [saa_pkg::IN_W-1:0] i_color_term_r, i_color_term_g, i_color_term_b;
    logic signed [saa_pkg::IN_W-1:0] i_opacity_logit;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [INDEX_BITS-1:0] o_vertex_index;
    logic [saa_pkg::SCALE_W-1:0] o_scale_a, o_scale_b, o_scale_c;
    logic [saa_pkg::CH_W-1:0]    o_red, o_green, o_blue, o_opacity;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [saa_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [saa_pkg::CFG_DATA_W-1:0] i_cfg_data;

    splat_attribute_activation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_first_vertex(i_first_vertex),
        .i_log_scale_a(i_log_scale_a), .i_log_scale_b(i_log_scale_b),
        .i_log_scale_c(i_log_scale_c),
        .i_color_term_r(i_color_term_r), .i_color_term_g(i_color_term_g),
        .i_color_term_b(i_color_term_b), .i_opacity_logit(i_opacity_logit),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_vertex_index(o_vertex_index),
        .o_scale_a(o_scale_a), .o_scale_b(o_scale_b), .o_scale_c(o_scale_c),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue), .o_opacity(o_opacity),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the block's registers and counters
    bit [24:0] cfg_max_vertices;
    bit [15:0] cfg_stride;
    bit [15:0] cfg_min_opacity;
    bit [31:0] cfg_max_scale;
    bit [6:0]  cfg_mask;
    bit [24:0] vtx_count;
    bit [15:0] stride_phase;
    bit [63:0] pow2_tab [TAB_DEPTH];

    t_splat_rec pending_vertices[$];
    int         errors;
    int         cycles;
    int         burst_left;
    bit         typed_on;
    t_splat_rec typed_rec;
    t_dir_row   dir_rows[$];

    // 2^(k/D) in Q30 from a floored series of exp
    function automatic void fill_pow2_tab();
        bit [63:0] z, term, sum;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            z = (64'(k) * LN2_Q30) / TAB_DEPTH;
            sum = ONE_Q30_64;
            term = ONE_Q30_64;
            for (int i = 1; i <= 20; i++) begin
                term = ((term * z) >> 30) / 64'(i);
                sum += term;
            end
            pow2_tab[k] = sum;
        end
    endfunction

    function automatic bit [63:0] round_shift(bit [63:0] x, int sh);
        if (sh <= 0) return x;
        if (sh > 62) return 64'd0;
        return (x + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // exp(v) as mantissa in Q30 times 2^n
    function automatic void exp_parts(longint v, output bit [63:0] mant, output int n);
        longint    p;
        bit [63:0] t, fd, k, r, a, m;
        p = v * LOG2E_Q32 + (64'sd1 <<< 61);
        t = 64'(p) >> FRAC_BITS;
        n = int'(t >> 32) - (1 << (29 - FRAC_BITS));
        fd = (t & 64'hFFFF_FFFF) * TAB_DEPTH;
        k = fd >> 32;
        r = fd & 64'hFFFF_FFFF;
        a = ((r * LN2_Q30) >> 32) / TAB_DEPTH;
        m = ONE_Q30_64 + a + ((a * a) >> 31) + ((((a * a) >> 30) * a) >> 30) / 6;
        if (k >= TAB_DEPTH) k = TAB_DEPTH - 1;
        mant = (pow2_tab[k] * m) >> 30;
    endfunction

    function automatic bit [31:0] scale_of(longint v);
        bit [63:0] mant, r;
        int        n;
        exp_parts(v, mant, n);
        if (n - 10 >= 3) return 32'hFFFF_FFFF;
        r = (n - 10 >= 0) ? (mant << (n - 10)) : round_shift(mant, 10 - n);
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic bit [15:0] opacity_of(longint v);
        bit [63:0] mant, e, den, num, q;
        int        n;
        exp_parts((v < 0) ? v : -v, mant, n);
        e = round_shift(mant, -n);
        if (e > ONE_Q30_64) e = ONE_Q30_64;
        den = ONE_Q30_64 + e;
        num = (v < 0) ? (e << 16) : (64'd1 << 46);
        q = (num + den / 2) / den;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic bit [15:0] channel_of(longint v);
        longint    p, c;
        bit [63:0] u;
        p = v * SH_C0_Q32 + (64'sd1 <<< 55);
        u = 64'(p) + (64'd1 << (FRAC_BITS + 15));
        c = 32768 + longint'(u >> (FRAC_BITS + 16)) - (64'sd1 <<< (39 - FRAC_BITS));
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
        return c[15:0];
    endfunction

    // activate one vertex and advance the file counters; returns keep
    function automatic bit activate_vertex(bit first, bit [23:0] raw [7],
                                           output t_splat_rec rec);
        longint    att [7];
        bit [31:0] big;
        bit        keep;
        if (first) begin
            vtx_count = 0;
            stride_phase = 0;
        end
        for (int i = 0; i < 7; i++) att[i] = longint'($signed(raw[i]));
        for (int i = 0; i < 3; i++) if (!cfg_mask[i]) att[i] = -(64'sd9 <<< (FRAC_BITS - 1));
        for (int i = 3; i < 6; i++) if (!cfg_mask[i]) att[i] = 0;
        if (!cfg_mask[6]) att[6] = 64'sd10 <<< FRAC_BITS;
        rec.index   = vtx_count[23:0];
        rec.scale_a = scale_of(att[0]);
        rec.scale_b = scale_of(att[1]);
        rec.scale_c = scale_of(att[2]);
        rec.red     = channel_of(att[3]);
        rec.green   = channel_of(att[4]);
        rec.blue    = channel_of(att[5]);
        rec.opacity = opacity_of(att[6]);
        big = rec.scale_a;
        if (rec.scale_b > big) big = rec.scale_b;
        if (rec.scale_c > big) big = rec.scale_c;
        keep = vtx_count < cfg_max_vertices && stride_phase == 0 &&
               rec.opacity >= cfg_min_opacity && big <= cfg_max_scale;
        if (stride_phase >= ((cfg_stride == 0) ? 16'd0 : cfg_stride - 16'd1))
            stride_phase = 0;
        else
            stride_phase++;
        if (vtx_count != 25'h1FF_FFFF) vtx_count++;
        return keep;
    endfunction

    function automatic void check_field(string name, bit [31:0] want, bit [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("splat_attribute_activation verification failed");
            $finish;
        end
    end

    // receiver stall pattern: quiet, light and heavy stretches
    always @(negedge i_clk) begin
        case ((cycles / 300) % 3)
            0: i_out_stall = 1'b0;
            1: i_out_stall = ($urandom_range(0, 1) == 0);
            default: i_out_stall = ($urandom_range(0, 9) != 0);
        endcase
    end

    // register write, input beat and result beat monitor
    always @(posedge i_clk) begin
        t_splat_rec rec, want;
        bit         keep;
        bit [23:0]  raw [7];
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    saa_pkg::CFG_MAX_VERTICES: cfg_max_vertices = i_cfg_data[24:0];
                    saa_pkg::CFG_STRIDE_COUNT: cfg_stride       = i_cfg_data[15:0];
                    saa_pkg::CFG_MIN_OPACITY:  cfg_min_opacity  = i_cfg_data[15:0];
                    saa_pkg::CFG_MAX_SCALE:    cfg_max_scale    = i_cfg_data;
                    saa_pkg::CFG_PRESENT_MASK: cfg_mask         = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                raw = '{i_log_scale_a, i_log_scale_b, i_log_scale_c, i_color_term_r,
                        i_color_term_g, i_color_term_b, i_opacity_logit};
                keep = activate_vertex(i_first_vertex, raw, rec);
                if (keep)
                    pending_vertices.insert(pending_vertices.size(),
                                            typed_on ? typed_rec : rec);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_vertices.size() == 0) begin
                    $display("%0t: result beat with none expected, index %0h",
                             $time, o_vertex_index);
                    errors++;
                end else begin
                    want = pending_vertices.pop_front();
                    check_field("vertex_index", want.index, o_vertex_index);
                    check_field("scale_a", want.scale_a, o_scale_a);
                    check_field("scale_b", want.scale_b, o_scale_b);
                    check_field("scale_c", want.scale_c, o_scale_c);
                    check_field("red", want.red, o_red);
                    check_field("green", want.green, o_green);
                    check_field("blue", want.blue, o_blue);
                    check_field("opacity", want.opacity, o_opacity);
                end
            end
        end
    end

    // one vertex beat, sender idles between bursts; starts and ends at negedge
    task automatic send_vertex(bit first, bit [23:0] raw [7], bit typed, t_splat_rec want);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) burst_left = 40;
        end
        burst_left--;
        i_in_valid      = 1'b1;
        i_first_vertex  = first;
        i_log_scale_a   = raw[0];
        i_log_scale_b   = raw[1];
        i_log_scale_c   = raw[2];
        i_color_term_r  = raw[3];
        i_color_term_g  = raw[4];
        i_color_term_b  = raw[5];
        i_opacity_logit = raw[6];
        typed_on        = typed;
        typed_rec       = want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        typed_on   = 1'b0;
    endtask

    // wait until every result is out and the block has settled
    task automatic drain_results();
        while (pending_vertices.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [saa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(bit [24:0] maxv, bit [15:0] stride, bit [15:0] min_op,
                             bit [31:0] max_sc, bit [6:0] mask);
        write_reg(saa_pkg::CFG_MAX_VERTICES, 32'(maxv));
        write_reg(saa_pkg::CFG_STRIDE_COUNT, 32'(stride));
        write_reg(saa_pkg::CFG_MIN_OPACITY, 32'(min_op));
        write_reg(saa_pkg::CFG_MAX_SCALE, max_sc);
        write_reg(saa_pkg::CFG_PRESENT_MASK, 32'(mask));
    endtask

    // attribute value: half in a meaningful range, the rest raw or extreme
    function automatic bit [23:0] pick_attr();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 24'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
            4: return 24'($urandom_range(0, 16 << 16));
            5, 6, 7: return 24'($urandom);
            8: return 24'h7F_FFFF;
            default: return 24'h80_0000;
        endcase
    endfunction

    task automatic random_vertices(int count, int first_odds);
        bit [23:0]  raw [7];
        t_splat_rec none;
        none = '{default: '0};
        for (int i = 0; i < count; i++) begin
            for (int j = 0; j < 7; j++) raw[j] = pick_attr();
            if ($urandom_range(0, 60) == 0) begin
                // pause until the block has emptied
                while (pending_vertices.size() != 0) @(negedge i_clk);
            end
            send_vertex($urandom_range(1, first_odds) == 1, raw, 1'b0, none);
        end
    endtask

    function automatic void add_row(bit first, bit [23:0] v0, bit [23:0] v1, bit [23:0] v2,
                                    bit typed, t_splat_rec want);
        t_dir_row row;
        row.first = first;
        row.attr  = '{v0, v0, v0, v1, v1, v1, v2};
        row.typed = typed;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    initial begin
        t_splat_rec none;
        none = '{default: '0};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_first_vertex = 1'b0;
        {i_log_scale_a, i_log_scale_b, i_log_scale_c} = '0;
        {i_color_term_r, i_color_term_g, i_color_term_b, i_opacity_logit} = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = saa_pkg::CFG_MAX_VERTICES;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        typed_on = 1'b0;
        cfg_max_vertices = 25'd16777216;
        cfg_stride = 16'd1;
        cfg_min_opacity = 16'd0;
        cfg_max_scale = 32'hFFFF_FFFF;
        cfg_mask = 7'h7F;
        vtx_count = '0;
        stride_phase = '0;
        fill_pow2_tab();

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero, extremes, sign and bit patterns, saturation edges
        add_row(1, 24'h0, 24'h0, 24'h0, 1,
                '{24'd0, 32'd1048576, 32'd1048576, 32'd1048576,
                  16'd32768, 16'd32768, 16'd32768, 16'd32768});
        add_row(0, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 1,
                '{24'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        add_row(0, 24'h80_0000, 24'h80_0000, 24'h80_0000, 1,
                '{24'd2, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0});
        add_row(0, 24'h7F_FFFF, 24'h80_0000, 24'hFF_FFFF, 0, none);
        add_row(0, 24'h01_0000, 24'hFF_0000, 24'h00_0001, 0, none);
        add_row(0, 24'hFF_FFFF, 24'h00_0001, 24'h80_0000, 0, none);
        add_row(0, 24'h0C_0000, 24'h02_0000, 24'h0A_0000, 0, none);
        add_row(0, 24'h08_0000, 24'hFE_0000, 24'hF6_0000, 0, none);
        add_row(1, 24'h00_0001, 24'h06_0000, 24'h10_0000, 0, none);
        add_row(0, 24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 0, none);
        add_row(0, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 0, none);
        add_row(0, 24'hF1_0000, 24'h03_8000, 24'hEC_0000, 0, none);
        add_row(0, 24'hB8_0000, 24'hF9_0000, 24'h18_0000, 0, none);
        foreach (dir_rows[i])
            send_vertex(dir_rows[i].first, dir_rows[i].attr, dir_rows[i].typed,
                        dir_rows[i].want);

        // reset settings
        random_vertices(110, 30);
        drain_results();

        // all defaults, stride changed in the middle of a file
        write_reg(CFG_NO_REG, 32'h0);
        write_all(25'd16777216, 16'd3, 16'd0, 32'hFFFF_FFFF, 7'h00);
        random_vertices(90, 40);
        drain_results();

        // stride of zero, some defaults, tight pruning
        write_all(25'd16777216, 16'd0, 16'd32768, 32'h0010_0000, 7'h2A);
        random_vertices(90, 20);
        drain_results();

        // short files past the vertex limit
        write_all(25'd5, 16'd1, 16'd0, 32'hFFFF_FFFF, 7'h7F);
        random_vertices(90, 4);
        drain_results();

        // limit of zero drops everything
        write_reg(saa_pkg::CFG_MAX_VERTICES, 32'd0);
        random_vertices(30, 5);
        drain_results();

        // widest stride keeps only the head of each file
        write_all(25'h1FF_FFFF, 16'd65535, 16'd0, 32'hFFFF_FFFF, 7'h55);
        random_vertices(80, 3);
        drain_results();

        // strictest thresholds
        write_all(25'd16777216, 16'd2, 16'd65535, 32'h0, 7'h40);
        random_vertices(50, 10);
        drain_results();

        // random settings
        repeat (3) begin
            write_all(25'($urandom), 16'($urandom_range(1, 4)), 16'($urandom_range(0, 40000)),
                      $urandom, 7'($urandom));
            random_vertices(60, 25);
            drain_results();
        end

        if (errors == 0)
            $display("splat_attribute_activation verification clean");
        else
            $display("splat_attribute_activation verification failed");
        $finish;
    end

endmodule
